FILE: rtl/prr_pkg.sv
// Shared types and constants for the pose reprojection residual pipeline.
// No dependencies.
package prr_pkg;

	localparam int PointW = 32;
	localparam int PixW   = 24;
	localparam int QuatW  = 16;
	localparam int PtW    = 33;
	localparam int ProdW  = 32;
	localparam int MatW   = 30;
	localparam int MulW   = 63;
	localparam int AccW   = 64;
	localparam int PosW   = 40;
	localparam int NumW   = 63;
	localparam int DenW   = 39;
	localparam int SumW   = 68;
	localparam int ResW   = 32;
	localparam int PoseLat = 5;
	localparam int HeadLat = PoseLat + 1;
	localparam int TotalLat = HeadLat + NumW + 2;

	localparam int OpRevBit  = 0;
	localparam int OpMonoBit = 1;

	typedef enum logic [2:0] {
		REG_QUAT   = 3'd0,
		REG_SHIFTX = 3'd1,
		REG_SHIFTY = 3'd2,
		REG_SHIFTZ = 3'd3,
		REG_FOCAL  = 3'd4,
		REG_CU     = 3'd5,
		REG_CV     = 3'd6,
		REG_DISP   = 3'd7
	} prr_reg_t;

	typedef struct packed {
		logic            mono;
		logic [PixW-1:0] lu;
		logic [PixW-1:0] lv;
		logic [PixW-1:0] ru;
		logic [PixW-1:0] rv;
	} prr_obs_t;

	typedef struct packed {
		prr_obs_t obs;
		logic     bad;
		logic     neg_x;
		logic     neg_y;
		logic     neg_d;
	} prr_tail_t;

endpackage

FILE: rtl/prr_delay.sv
// Fixed-depth payload delay line used to keep side data aligned with the pipeline.
// Depends on nothing.
module prr_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] taps_q [DEPTH];

	always_ff @(posedge clk) begin
		taps_q[0] <= din;
		for (int k = 1; k < DEPTH; k++) begin
			taps_q[k] <= taps_q[k-1];
		end
	end

	assign dout = taps_q[DEPTH-1];
endmodule

FILE: rtl/prr_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on nothing.
module prr_div #(
	parameter int NUM_W = 63,
	parameter int DEN_W = 39
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);
	logic [DEN_W-1:0] rem_s  [NUM_W];
	logic [NUM_W-1:0] work_s [NUM_W];
	logic [DEN_W-1:0] den_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] work_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign work_in = num;
			assign den_in  = den;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign work_in = work_s[k-1];
			assign den_in  = den_s[k-1];
		end

		assign trial = {rem_in, work_in[NUM_W-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			work_s[k] <= {work_in[NUM_W-2:0], ge};
			den_s[k]  <= den_in;
		end
	end

	assign quo = work_s[NUM_W-1];
endmodule

FILE: rtl/prr_pose.sv
// Five-stage pose pipeline: quaternion products, rotation matrix, matrix-vector
// products, accumulation and translation. Depends on prr_pkg.
module prr_pose import prr_pkg::*; (
	input  logic                     clk,
	input  logic [1:0]               op,
	input  logic signed [PointW-1:0] point_x,
	input  logic signed [PointW-1:0] point_y,
	input  logic signed [PointW-1:0] point_z,
	input  logic [4*QuatW-1:0]       quat,
	input  logic signed [PointW-1:0] shift_x,
	input  logic signed [PointW-1:0] shift_y,
	input  logic signed [PointW-1:0] shift_z,
	output logic signed [PosW-1:0]   pos_x,
	output logic signed [PosW-1:0]   pos_y,
	output logic signed [PosW-1:0]   pos_z
);
	logic signed [QuatW-1:0] qa, qb, qc, qd;
	logic rev, mono;
	logic signed [PointW-1:0] pin [3];
	logic signed [PointW-1:0] tin [3];
	logic signed [PtW-1:0]    pt_c [3];

	// Stage 1: rotated-frame input point and the nine quaternion products.
	logic signed [PtW-1:0]   pt_s1 [3];
	logic signed [ProdW-1:0] ab_s1, ac_s1, ad_s1, bb_s1, bc_s1, bd_s1, cc_s1, cd_s1, dd_s1;
	logic                    addt_s1;
	// Stage 2: matrix entries scaled down to Q.24.
	logic signed [MatW-1:0]  m_s2 [3][3];
	logic signed [PtW-1:0]   pt_s2 [3];
	logic                    addt_s2;
	// Stage 3: the nine entry-by-coordinate products.
	logic signed [MulW-1:0]  pr_s3 [3][3];
	logic signed [PtW-1:0]   pt_s3 [3];
	logic                    addt_s3;
	// Stage 4: rotated point; stage 5: translated point.
	logic signed [PosW-1:0]  rot_s4 [3];
	logic                    addt_s4;
	logic signed [PosW-1:0]  pos_s5 [3];

	assign qa   = quat[4*QuatW-1:3*QuatW];
	assign qb   = quat[3*QuatW-1:2*QuatW];
	assign qc   = quat[2*QuatW-1:QuatW];
	assign qd   = quat[QuatW-1:0];
	assign rev  = op[OpRevBit];
	assign mono = op[OpMonoBit];
	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;
	assign tin[0] = shift_x;
	assign tin[1] = shift_y;
	assign tin[2] = shift_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (rev && !mono) begin
				pt_c[i] = PtW'(pin[i]) - PtW'(tin[i]);
			end else begin
				pt_c[i] = PtW'(pin[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		// The conjugate rotation flips the sign of the products that pair w with x, y or z.
		ab_s1   <= rev ? -(qa * qb) : qa * qb;
		ac_s1   <= rev ? -(qa * qc) : qa * qc;
		ad_s1   <= rev ? -(qa * qd) : qa * qd;
		bb_s1   <= qb * qb;
		bc_s1   <= qb * qc;
		bd_s1   <= qb * qd;
		cc_s1   <= qc * qc;
		cd_s1   <= qc * qd;
		dd_s1   <= qd * qd;
		addt_s1 <= !rev && !mono;
		for (int i = 0; i < 3; i++) begin
			pt_s1[i] <= pt_c[i];
		end
	end

	// Entry = 2*s in Q.28, floored to Q.24, equals s shifted right by three.
	function automatic logic signed [MatW-1:0] ent(input logic signed [ProdW:0] s);
		logic signed [ProdW:0] t;
		t = s >>> 3;
		return t[MatW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		m_s2[0][0] <= ent(-(ProdW+1)'(cc_s1) - (ProdW+1)'(dd_s1));
		m_s2[0][1] <= ent((ProdW+1)'(bc_s1) - (ProdW+1)'(ad_s1));
		m_s2[0][2] <= ent((ProdW+1)'(ac_s1) + (ProdW+1)'(bd_s1));
		m_s2[1][0] <= ent((ProdW+1)'(ad_s1) + (ProdW+1)'(bc_s1));
		m_s2[1][1] <= ent(-(ProdW+1)'(bb_s1) - (ProdW+1)'(dd_s1));
		m_s2[1][2] <= ent((ProdW+1)'(cd_s1) - (ProdW+1)'(ab_s1));
		m_s2[2][0] <= ent((ProdW+1)'(bd_s1) - (ProdW+1)'(ac_s1));
		m_s2[2][1] <= ent((ProdW+1)'(ab_s1) + (ProdW+1)'(cd_s1));
		m_s2[2][2] <= ent(-(ProdW+1)'(bb_s1) - (ProdW+1)'(cc_s1));
		addt_s2    <= addt_s1;
		for (int i = 0; i < 3; i++) begin
			pt_s2[i] <= pt_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		addt_s3 <= addt_s2;
		for (int i = 0; i < 3; i++) begin
			pt_s3[i] <= pt_s2[i];
			for (int j = 0; j < 3; j++) begin
				pr_s3[i][j] <= MulW'(m_s2[i][j]) * MulW'(pt_s2[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [AccW-1:0] acc;
		addt_s4 <= addt_s3;
		for (int i = 0; i < 3; i++) begin
			acc = ((AccW)'(pt_s3[i]) <<< 24) + AccW'(pr_s3[i][0])
				+ AccW'(pr_s3[i][1]) + AccW'(pr_s3[i][2]);
			rot_s4[i] <= acc[AccW-1:AccW-PosW];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pos_s5[i] <= addt_s4 ? rot_s4[i] + PosW'(tin[i]) : rot_s4[i];
		end
	end

	assign pos_x = pos_s5[0];
	assign pos_y = pos_s5[1];
	assign pos_z = pos_s5[2];
endmodule

FILE: rtl/pose_reprojection_residual.sv
// Top level of the pose reprojection residual pipeline.
// Depends on prr_pkg, prr_pose, prr_div and prr_delay.
//
// Usage: software writes the pose and camera registers over the cfg channel
// (cfg_valid/cfg_ready, cfg_index selects the register, cfg_data the value)
// while the pipeline is empty. cfg_ready is always high, so each write is a
// one-cycle transfer. Feature points are then issued on the command channel:
// a transfer happens on every clock edge with start high and busy low, and
// busy stays low, so one point may be issued in every cycle.
// Each point yields exactly one result, presented with a one-cycle done
// strobe. The path runs through five pose stages, one stage that forms
// the numerators, a 63-stage divider that produces one quotient bit per
// stage, and two stages of residual math.
// Throughput is one point per cycle; the receiver cannot stall and must take
// each result in the cycle that done is high.
// Asynchronous reset empties the pipeline (no done strobes follow) and loads
// the registers with the identity rotation and zero for all other values.
module pose_reprojection_residual import prr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               op,
	input  logic signed [PointW-1:0] point_x,
	input  logic signed [PointW-1:0] point_y,
	input  logic signed [PointW-1:0] point_z,
	input  logic [PixW-1:0]          left_obs_u,
	input  logic [PixW-1:0]          left_obs_v,
	input  logic [PixW-1:0]          right_obs_u,
	input  logic [PixW-1:0]          right_obs_v,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [4*QuatW-1:0]       cfg_data,
	output logic                     done,
	output logic signed [ResW-1:0]   res_left_u,
	output logic signed [ResW-1:0]   res_left_v,
	output logic signed [ResW-1:0]   res_right_u,
	output logic signed [ResW-1:0]   res_right_v,
	output logic                     depth_bad,
	output logic                     saturated
);
	localparam logic signed [SumW-1:0] ResMax = SumW'(64'sd2147483647);
	localparam logic signed [SumW-1:0] ResMin = -SumW'(64'sd2147483648);

	// Configuration registers.
	logic [4*QuatW-1:0]       quat_q;
	logic signed [PointW-1:0] shx_q, shy_q, shz_q, disp_q;
	logic [PixW-1:0]          focal_q, cu_q, cv_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q  <= {2'b01, {(4*QuatW-2){1'b0}}};
			shx_q   <= '0;
			shy_q   <= '0;
			shz_q   <= '0;
			focal_q <= '0;
			cu_q    <= '0;
			cv_q    <= '0;
			disp_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (prr_reg_t'(cfg_index))
				REG_QUAT:   quat_q  <= cfg_data;
				REG_SHIFTX: shx_q   <= cfg_data[PointW-1:0];
				REG_SHIFTY: shy_q   <= cfg_data[PointW-1:0];
				REG_SHIFTZ: shz_q   <= cfg_data[PointW-1:0];
				REG_FOCAL:  focal_q <= cfg_data[PixW-1:0];
				REG_CU:     cu_q    <= cfg_data[PixW-1:0];
				REG_CV:     cv_q    <= cfg_data[PixW-1:0];
				REG_DISP:   disp_q  <= cfg_data[PointW-1:0];
			endcase
		end
	end

	// Valid bits travel alongside the data through every stage.
	logic [TotalLat-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[TotalLat-2:0], start && !busy};
		end
	end

	// Pose the point.
	logic signed [PosW-1:0] px, py, pz;

	prr_pose u_pose (
		.clk     (clk),
		.op      (op),
		.point_x (point_x),
		.point_y (point_y),
		.point_z (point_z),
		.quat    (quat_q),
		.shift_x (shx_q),
		.shift_y (shy_q),
		.shift_z (shz_q),
		.pos_x   (px),
		.pos_y   (py),
		.pos_z   (pz)
	);

	// The observations and the mono flag wait beside the pose stages.
	prr_obs_t obs_in, obs_s6;

	assign obs_in.mono = op[OpMonoBit];
	assign obs_in.lu   = left_obs_u;
	assign obs_in.lv   = left_obs_v;
	assign obs_in.ru   = right_obs_u;
	assign obs_in.rv   = right_obs_v;

	prr_delay #(.WIDTH($bits(prr_obs_t)), .DEPTH(HeadLat)) u_head_dly (
		.clk  (clk),
		.din  (obs_in),
		.dout (obs_s6)
	);

	// Stage 6: depth check and divider numerators as sign and magnitude.
	// Because the depth is positive whenever its result matters, truncation
	// toward zero is the magnitude quotient with the numerator's sign applied.
	logic [PosW-1:0]   ax, ay;
	logic [AccW-1:0]   mx, my;
	logic [NumW-1:0]   nx_s6, ny_s6, nd_s6;
	logic [DenW-1:0]   den_s6;
	logic              bad_s6, negx_s6, negy_s6, negd_s6;
	logic [PointW-1:0] ad;

	assign ax = px[PosW-1] ? PosW'(-px) : PosW'(px);
	assign ay = py[PosW-1] ? PosW'(-py) : PosW'(py);
	assign ad = disp_q[PointW-1] ? PointW'(-disp_q) : PointW'(disp_q);
	assign mx = AccW'(focal_q) * AccW'(ax);
	assign my = AccW'(focal_q) * AccW'(ay);

	always_ff @(posedge clk) begin
		nx_s6   <= mx[NumW-1:0];
		ny_s6   <= my[NumW-1:0];
		nd_s6   <= {{(NumW-PointW-12){1'b0}}, ad, 12'b0};
		den_s6  <= pz[DenW-1:0];
		bad_s6  <= (pz[PosW-1] || pz == '0);
		negx_s6 <= px[PosW-1];
		negy_s6 <= py[PosW-1];
		negd_s6 <= disp_q[PointW-1];
	end

	logic [NumW-1:0] qx, qy, qd;

	prr_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div_x (
		.clk (clk), .num (nx_s6), .den (den_s6), .quo (qx)
	);
	prr_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div_y (
		.clk (clk), .num (ny_s6), .den (den_s6), .quo (qy)
	);
	prr_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div_d (
		.clk (clk), .num (nd_s6), .den (den_s6), .quo (qd)
	);

	prr_tail_t tail_s6, tail_dv;

	assign tail_s6.obs   = obs_s6;
	assign tail_s6.bad   = bad_s6;
	assign tail_s6.neg_x = negx_s6;
	assign tail_s6.neg_y = negy_s6;
	assign tail_s6.neg_d = negd_s6;

	prr_delay #(.WIDTH($bits(prr_tail_t)), .DEPTH(NumW)) u_tail_dly (
		.clk  (clk),
		.din  (tail_s6),
		.dout (tail_dv)
	);

	// First residual stage: signed quotients and projected pixel positions.
	logic signed [SumW-1:0] sqx, sqy, sqd;
	logic signed [SumW-1:0] u_s70, v_s70, dz_s70;
	prr_tail_t              tail_s70;

	assign sqx = tail_dv.neg_x ? -SumW'(qx) : SumW'(qx);
	assign sqy = tail_dv.neg_y ? -SumW'(qy) : SumW'(qy);
	assign sqd = tail_dv.neg_d ? -SumW'(qd) : SumW'(qd);

	always_ff @(posedge clk) begin
		u_s70    <= sqx + SumW'(cu_q);
		v_s70    <= sqy + SumW'(cv_q);
		dz_s70   <= sqd;
		tail_s70 <= tail_dv;
	end

	// Second residual stage: differences, clipping and the special cases.
	function automatic logic [ResW:0] clip(input logic signed [SumW-1:0] x);
		if (x > ResMax) begin
			return {1'b1, ResMax[ResW-1:0]};
		end else if (x < ResMin) begin
			return {1'b1, ResMin[ResW-1:0]};
		end
		return {1'b0, x[ResW-1:0]};
	endfunction

	logic [ResW:0] c0, c1, c2, c3;
	logic [ResW-1:0] r0_s71, r1_s71, r2_s71, r3_s71;
	logic            bad_s71, sat_s71;

	assign c0 = clip(u_s70 - SumW'(tail_s70.obs.lu));
	assign c1 = clip(v_s70 - SumW'(tail_s70.obs.lv));
	assign c2 = clip(u_s70 + dz_s70 - SumW'(tail_s70.obs.ru));
	assign c3 = clip(v_s70 - SumW'(tail_s70.obs.rv));

	always_ff @(posedge clk) begin
		bad_s71 <= tail_s70.bad;
		if (tail_s70.bad) begin
			// Depth not positive: every residual and the clip flag read zero.
			r0_s71  <= '0;
			r1_s71  <= '0;
			r2_s71  <= '0;
			r3_s71  <= '0;
			sat_s71 <= 1'b0;
		end else if (tail_s70.obs.mono) begin
			// Mono: only the left residuals exist and count toward the flag.
			r0_s71  <= c0[ResW-1:0];
			r1_s71  <= c1[ResW-1:0];
			r2_s71  <= '0;
			r3_s71  <= '0;
			sat_s71 <= c0[ResW] || c1[ResW];
		end else begin
			r0_s71  <= c0[ResW-1:0];
			r1_s71  <= c1[ResW-1:0];
			r2_s71  <= c2[ResW-1:0];
			r3_s71  <= c3[ResW-1:0];
			sat_s71 <= c0[ResW] || c1[ResW] || c2[ResW] || c3[ResW];
		end
	end

	assign done        = vld_s[TotalLat-1];
	assign res_left_u  = r0_s71;
	assign res_left_v  = r1_s71;
	assign res_right_u = r2_s71;
	assign res_right_v = r3_s71;
	assign depth_bad   = bad_s71;
	assign saturated   = sat_s71;
endmodule
